[rtl/sha1s_pkg.sv]
// Shared types and constants for the SHA-1 stream hasher.
// Used by the front end, the word queue, the core and the top level.
package sha1s_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;
   localparam int unsigned ROUNDS      = 80;
   localparam int unsigned COUNT_W     = 61;

   localparam logic [31:0] H_INIT [5] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };
   localparam logic [31:0] K_00_19 = 32'h5A827999;
   localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
   localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
   localparam logic [31:0] K_60_79 = 32'hCA62C1D6;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   // word kinds after classification
   localparam logic [1:0] OP_BYTE     = 2'd0;
   localparam logic [1:0] OP_END      = 2'd1;
   localparam logic [1:0] OP_BYTE_END = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } qhead_type;

endpackage

[rtl/sha1s_if.sv]
// Valid/ready channel interfaces for request bytes and digest words.
// Depends on nothing.
interface sha1s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, output data_byte, output byte_present,
                   output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input byte_present,
                   input end_of_message, output ready);
endinterface

interface sha1s_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic        last_word;

   modport source (output valid, output digest_word, output last_word, input ready);
   modport sink   (input valid, input digest_word, input last_word, output ready);
endinterface

[rtl/sha1s_front.sv]
// Front end: takes request words, drops empty ones and classifies the rest.
// Depends on sha1s_pkg and sha1s_req_if.
module sha1s_front (
   sha1s_req_if.sink         req_ch,
   input  logic              q_full,
   output logic              push,
   output sha1s_pkg::entry_type push_entry
);

   logic useful;

   assign useful       = req_ch.byte_present | req_ch.end_of_message;
   // empty words are taken at once and vanish
   assign req_ch.ready = !q_full || !useful;
   assign push         = req_ch.valid && useful && !q_full;

   always_comb begin
      push_entry.data = req_ch.data_byte;
      if (req_ch.byte_present && req_ch.end_of_message) begin
         push_entry.op = sha1s_pkg::OP_BYTE_END;
      end else if (req_ch.byte_present) begin
         push_entry.op = sha1s_pkg::OP_BYTE;
      end else begin
         push_entry.op = sha1s_pkg::OP_END;
      end
   end

endmodule

[rtl/sha1s_queue.sv]
// Short register queue between the front end and the compression core.
// Depends on sha1s_pkg.
module sha1s_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sha1s_pkg::entry_type push_entry,
   output logic                 full,
   input  logic                 pop,
   output sha1s_pkg::qhead_type head
);

   sha1s_pkg::entry_type              mem_ff [sha1s_pkg::QUEUE_DEPTH];
   logic [sha1s_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [sha1s_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [sha1s_pkg::QPTR_W:0]        fill_ff, fill_in;
   logic                              do_push, do_pop;

   assign full       = (fill_ff == (sha1s_pkg::QPTR_W+1)'(sha1s_pkg::QUEUE_DEPTH));
   assign head.valid = (fill_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[rtl/sha1s_core.sv]
// Back end: block gathering, padding, one SHA-1 round per cycle and digest output.
// Depends on sha1s_pkg and sha1s_rsp_if.
module sha1s_core (
   input  logic                 clock,
   input  logic                 reset,
   input  sha1s_pkg::qhead_type head,
   output logic                 pop,
   sha1s_rsp_if.source          rsp_ch
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_ADD   = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [31:0] h_ff [5];
   logic [31:0] h_in [5];
   logic [31:0] v_ff [5];
   logic [31:0] v_in [5];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [6:0]  round_ff, round_in;
   logic [2:0]  widx_ff, widx_in;
   logic [sha1s_pkg::COUNT_W-1:0] count_ff, count_in;
   logic        pend_end_ff, pend_end_in;
   logic        fin_ff, fin_in;
   logic        second_ff, second_in;

   logic [5:0]  idx;
   logic [63:0] bit_len;
   logic [31:0] f_val, k_val, t_val, w_new;
   logic [31:0] sum [5];
   logic [5:0]  pos;
   logic        has_byte, has_end;

   assign idx      = count_ff[5:0];
   assign bit_len  = {count_ff, 3'b000};
   assign has_byte = (head.entry.op == sha1s_pkg::OP_BYTE) ||
                     (head.entry.op == sha1s_pkg::OP_BYTE_END);
   assign has_end  = (head.entry.op == sha1s_pkg::OP_END) ||
                     (head.entry.op == sha1s_pkg::OP_BYTE_END);
   assign pop      = (state_ff == ST_IDLE) && !pend_end_ff && head.valid;

   assign rsp_ch.valid       = (state_ff == ST_EMIT);
   assign rsp_ch.digest_word = h_ff[widx_ff];
   assign rsp_ch.last_word   = (widx_ff == 3'd4);

   // round function and schedule
   always_comb begin
      if (round_ff inside {[7'd0:7'd19]}) begin
         f_val = (v_ff[1] & v_ff[2]) | (~v_ff[1] & v_ff[3]);
         k_val = sha1s_pkg::K_00_19;
      end else if (round_ff inside {[7'd20:7'd39]}) begin
         f_val = v_ff[1] ^ v_ff[2] ^ v_ff[3];
         k_val = sha1s_pkg::K_20_39;
      end else if (round_ff inside {[7'd40:7'd59]}) begin
         f_val = (v_ff[1] & v_ff[2]) | (v_ff[1] & v_ff[3]) | (v_ff[2] & v_ff[3]);
         k_val = sha1s_pkg::K_40_59;
      end else begin
         f_val = v_ff[1] ^ v_ff[2] ^ v_ff[3];
         k_val = sha1s_pkg::K_60_79;
      end
      t_val = {v_ff[0][26:0], v_ff[0][31:27]} + f_val + v_ff[4] + k_val + w_ff[0];
      w_new = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      w_new = {w_new[30:0], w_new[31]};
      for (int i = 0; i < 5; i++) begin
         sum[i] = h_ff[i] + v_ff[i];
      end
   end

   always_comb begin
      state_in    = state_ff;
      h_in        = h_ff;
      v_in        = v_ff;
      w_in        = w_ff;
      round_in    = round_ff;
      widx_in     = widx_ff;
      count_in    = count_ff;
      pend_end_in = pend_end_ff;
      fin_in      = fin_ff;
      second_in   = second_ff;
      pos         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (pend_end_ff) begin
               // pad in place: 0x80 at the next byte, zeros after it
               for (int j = 0; j < 16; j++) begin
                  for (int b = 0; b < 4; b++) begin
                     pos = 6'(4 * j + b);
                     if (pos == idx) begin
                        w_in[j][31-8*b -: 8] = sha1s_pkg::PAD_BYTE;
                     end else if (pos > idx) begin
                        w_in[j][31-8*b -: 8] = 8'h00;
                     end
                  end
               end
               if (idx >= 6'd56) begin
                  second_in = 1'b1;
               end else begin
                  w_in[14] = bit_len[63:32];
                  w_in[15] = bit_len[31:0];
               end
               pend_end_in = 1'b0;
               fin_in      = 1'b1;
               v_in        = h_ff;
               round_in    = '0;
               state_in    = ST_ROUND;
            end else if (head.valid) begin
               if (has_byte) begin
                  for (int j = 0; j < 16; j++) begin
                     if (idx[5:2] == 4'(j)) begin
                        for (int b = 0; b < 4; b++) begin
                           if (idx[1:0] == 2'(b)) begin
                              w_in[j][31-8*b -: 8] = head.entry.data;
                           end
                        end
                     end
                  end
                  count_in = count_ff + 1'b1;
                  if (idx == 6'd63) begin
                     v_in     = h_ff;
                     round_in = '0;
                     state_in = ST_ROUND;
                  end
               end
               pend_end_in = has_end;
            end
         end
         ST_ROUND: begin
            v_in[0] = t_val;
            v_in[1] = v_ff[0];
            v_in[2] = {v_ff[1][1:0], v_ff[1][31:2]};
            v_in[3] = v_ff[2];
            v_in[4] = v_ff[3];
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i+1];
            end
            w_in[15] = w_new;
            round_in = round_ff + 1'b1;
            if (round_ff == 7'(sha1s_pkg::ROUNDS - 1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            h_in = sum;
            if (second_ff) begin
               // length-only block
               for (int i = 0; i < 14; i++) begin
                  w_in[i] = '0;
               end
               w_in[14]  = bit_len[63:32];
               w_in[15]  = bit_len[31:0];
               second_in = 1'b0;
               v_in      = sum;
               round_in  = '0;
               state_in  = ST_ROUND;
            end else if (fin_ff) begin
               widx_in  = '0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_ch.ready) begin
               widx_in = widx_ff + 1'b1;
               if (widx_ff == 3'd4) begin
                  h_in     = sha1s_pkg::H_INIT;
                  count_in = '0;
                  fin_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         h_ff        <= sha1s_pkg::H_INIT;
         count_ff    <= '0;
         pend_end_ff <= 1'b0;
         fin_ff      <= 1'b0;
         second_ff   <= 1'b0;
         round_ff    <= '0;
         widx_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         h_ff        <= h_in;
         count_ff    <= count_in;
         pend_end_ff <= pend_end_in;
         fin_ff      <= fin_in;
         second_ff   <= second_in;
         round_ff    <= round_in;
         widx_ff     <= widx_in;
      end
      v_ff <= v_in;
      w_ff <= w_in;
   end

endmodule

[rtl/sha1_stream_hasher.sv]
// SHA-1 stream hasher: a byte word enters the register queue; the core takes one byte a
// cycle while idle, and each full 64-byte block holds it through 80 rounds and the add.
// An end word is padded in place, then runs one or two blocks of 80 rounds and the add,
// and then five digest words follow, one a cycle while the sink is ready.
// Synchronous reset restores the initial hash words, a zero count and an empty queue.
module sha1_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   sha1s_req_if.sink   req_ch,
   sha1s_rsp_if.source rsp_ch
);

   logic                 push, q_full, pop;
   sha1s_pkg::entry_type push_entry;
   sha1s_pkg::qhead_type head;

   sha1s_front u_front (
      .req_ch     (req_ch),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   sha1s_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head       (head)
   );

   sha1s_core u_core (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

[tb/testbench.sv]
// Self-checking bench for sha1_stream_hasher: drives message bytes, predicts each digest.
// Depends on the RTL package and the channel interfaces in rtl/sha1s_if.sv.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET  = 460;
   localparam int STALL_CYCLES = 400;
   localparam int SETTLE       = 300;
   localparam int WATCHDOG_MAX = 4000;

   localparam logic [31:0] SHA1_IV [5] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };
   localparam logic [31:0] RK0 = 32'h5A827999;
   localparam logic [31:0] RK1 = 32'h6ED9EBA1;
   localparam logic [31:0] RK2 = 32'h8F1BBCDC;
   localparam logic [31:0] RK3 = 32'hCA62C1D6;
   localparam logic [7:0]  MARK_BYTE = 8'h80;

   typedef struct {
      logic [7:0] data_byte;
      bit         byte_present;
      bit         end_of_message;
      bit         drain_first;
   } hash_item_type;

   typedef struct {
      logic [31:0] digest_word;
      bit          last_word;
   } digest_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sha1s_req_if req_ch ();
   sha1s_rsp_if rsp_ch ();

   sha1_stream_hasher DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [31:0] hash_state [5];
   logic [7:0]  blk_buf [64];
   logic [60:0] msg_len;

   hash_item_type   byte_plan [$];
   digest_word_type digest_expect [$];

   hash_item_type cur_item;
   bit  send_now;
   bit  nothing_owed = 1'b1;
   bit  stall_done = 1'b0;
   int  stall_left = 0;
   int  items_taken = 0;
   int  words_seen = 0;
   int  planned = 0;
   int  fault_count = 0;
   int  quiet_cycles = 0;
   digest_word_type want;

   task automatic sha1_restart();
      for (int i = 0; i < 5; i++) hash_state[i] = SHA1_IV[i];
      msg_len = '0;
   endtask

   task automatic sha1_compress();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int r = 0; r < 16; r++)
         w[r] = {blk_buf[4*r], blk_buf[4*r+1], blk_buf[4*r+2], blk_buf[4*r+3]};
      for (int r = 16; r < 80; r++) begin
         t = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
         w[r] = {t[30:0], t[31]};
      end
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
      d = hash_state[3]; e = hash_state[4];
      for (int r = 0; r < 80; r++) begin
         if (r < 20) begin
            f = (b & c) | (~b & d); k = RK0;
         end else if (r < 40) begin
            f = b ^ c ^ d; k = RK1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d); k = RK2;
         end else begin
            f = b ^ c ^ d; k = RK3;
         end
         t = {a[26:0], a[31:27]} + f + e + k + w[r];
         e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
      hash_state[3] += d; hash_state[4] += e;
   endtask

   // byte first, then the end mark; an end queues five digest words
   task automatic absorb_item(input hash_item_type it);
      logic [5:0]  idx;
      logic [63:0] bit_len;
      digest_word_type dw;
      if (it.byte_present) begin
         idx = msg_len[5:0];
         blk_buf[idx] = it.data_byte;
         msg_len = msg_len + 1'b1;
         if (idx == 6'd63) sha1_compress();
      end
      if (it.end_of_message) begin
         idx = msg_len[5:0];
         blk_buf[idx] = MARK_BYTE;
         for (int i = idx + 1; i < 64; i++) blk_buf[i] = 8'h00;
         // no room for the length: spill into a second block
         if (idx >= 6'd56) begin
            sha1_compress();
            for (int i = 0; i < 56; i++) blk_buf[i] = 8'h00;
         end
         bit_len = {msg_len, 3'b000};
         for (int i = 0; i < 8; i++) blk_buf[56+i] = bit_len[63-8*i -: 8];
         sha1_compress();
         for (int i = 0; i < 5; i++) begin
            dw.digest_word = hash_state[i];
            dw.last_word   = (i == 4);
            digest_expect.push_back(dw);
         end
         sha1_restart();
      end
   endtask

   task automatic queue_item(input logic [7:0] data, input bit present, input bit endm,
                             input bit drain);
      hash_item_type it;
      it.data_byte = data;
      it.byte_present = present;
      it.end_of_message = endm;
      it.drain_first = drain;
      byte_plan.push_back(it);
      if (present || endm) planned++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            absorb_item(cur_item);
            items_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            send_now = byte_plan.size() != 0 &&
                       ((items_taken >= 150 && items_taken < 260) ||
                        $urandom_range(0, 99) >= 10);
            if (send_now && byte_plan[0].drain_first && !nothing_owed) send_now = 1'b0;
            if (send_now) begin
               cur_item = byte_plan.pop_front();
               req_ch.data_byte      <= cur_item.data_byte;
               req_ch.byte_present   <= cur_item.byte_present;
               req_ch.end_of_message <= cur_item.end_of_message;
               req_ch.valid          <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(negedge clock) nothing_owed <= (digest_expect.size() == 0);

   // monitor and receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            words_seen++;
            if (digest_expect.size() == 0) begin
               $error("unexpected digest word %h", rsp_ch.digest_word);
               fault_count++;
            end else begin
               want = digest_expect.pop_front();
               if (rsp_ch.digest_word !== want.digest_word) begin
                  $error("digest_word: expected %h, actual %h",
                         want.digest_word, rsp_ch.digest_word);
                  fault_count++;
               end
               if (rsp_ch.last_word !== want.last_word) begin
                  $error("last_word: expected %0d, actual %0d",
                         want.last_word, rsp_ch.last_word);
                  fault_count++;
               end
            end
         end
         // one long hold-off so the input side backs up
         if (!stall_done && words_seen >= 40) begin
            stall_left = STALL_CYCLES;
            stall_done = 1'b1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= (words_seen >= 50 && words_seen < 90) ||
                            $urandom_range(0, 99) >= 10;
         end
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int  sel, len;
      bit  merge_end, drain, drain_set;
      req_ch.valid = 1'b0;
      req_ch.data_byte = 8'h00;
      req_ch.byte_present = 1'b0;
      req_ch.end_of_message = 1'b0;
      rsp_ch.ready = 1'b0;
      sha1_restart();
      for (int i = 0; i < 64; i++) blk_buf[i] = 8'h00;

      // directed: idle word, empty message, "abc" with end on last byte
      queue_item(8'hA5, 1'b0, 1'b0, 1'b0);
      queue_item(8'h00, 1'b0, 1'b1, 1'b0);
      queue_item(8'h61, 1'b1, 1'b0, 1'b0);
      queue_item(8'h62, 1'b1, 1'b0, 1'b0);
      queue_item(8'h63, 1'b1, 1'b1, 1'b0);
      // byte extremes, idle word mid-message, separate end, then byte-with-end and empty messages
      queue_item(8'h00, 1'b1, 1'b0, 1'b0);
      queue_item(8'hFF, 1'b1, 1'b0, 1'b0);
      queue_item(8'h5A, 1'b0, 1'b0, 1'b0);
      queue_item(8'hFF, 1'b0, 1'b1, 1'b0);
      queue_item(8'hFF, 1'b1, 1'b1, 1'b0);
      queue_item(8'h00, 1'b1, 1'b1, 1'b0);
      queue_item(8'h3C, 1'b0, 1'b1, 1'b0);
      queue_item(8'hC3, 1'b0, 1'b1, 1'b0);

      drain_set = 1'b0;
      while (planned < ITEM_TARGET) begin
         sel = $urandom_range(0, 99);
         if (sel < 8) begin
            repeat ($urandom_range(1, 3)) queue_item(8'($urandom), 1'b0, 1'b0, 1'b0);
         end else begin
            if (sel < 50) len = $urandom_range(0, 12);
            else if (sel < 80) len = ($urandom_range(0, 1) ? 48 : 112) + $urandom_range(0, 20);
            else len = $urandom_range(13, 200);
            merge_end = (len > 0) && $urandom_range(0, 1);
            drain = !drain_set && planned >= 250;
            if (drain) drain_set = 1'b1;
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 99) < 6) queue_item(8'($urandom), 1'b0, 1'b0, 1'b0);
               queue_item(8'($urandom), 1'b1, merge_end && i == len - 1, drain && i == 0);
            end
            if (!merge_end) queue_item(8'($urandom), 1'b0, 1'b1, drain && len == 0);
         end
      end

      @(negedge clock);
      while (byte_plan.size() != 0 || req_ch.valid || digest_expect.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
      while (digest_expect.size() != 0) begin
         want = digest_expect.pop_front();
         $error("digest_word %h never arrived", want.digest_word);
         fault_count++;
      end
      if (fault_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

endmodule

[filelist.f]
rtl/sha1s_pkg.sv
rtl/sha1s_if.sv
rtl/sha1s_front.sv
rtl/sha1s_queue.sv
rtl/sha1s_core.sv
rtl/sha1_stream_hasher.sv
tb/testbench.sv
